[rtl/kms_pkg.sv]
// Shared constants, key map tables and lookup functions of the matrix scan encoder.
package kms_pkg;

	localparam int ROWS     = 16;
	localparam int COLUMNS  = 8;
	localparam int KEYS     = 61;
	localparam int LAYERS   = 2;
	localparam int MAP_ROWS = 8;

	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int KEY_W   = $clog2(KEYS);
	localparam int LAYER_W = $clog2(LAYERS);
	localparam int CODE_W  = 8;

	localparam logic [ROW_W-1:0] FN_ROW = ROW_W'(6);
	localparam logic [COL_W-1:0] FN_COL = COL_W'(7);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

	localparam logic [CODE_W-1:0] CODE_ESC    = 8'd41;
	localparam logic [CODE_W-1:0] CODE_TILDE  = 8'd53;
	localparam logic [CODE_W-1:0] CODE_LSHIFT = 8'd225;
	localparam logic [CODE_W-1:0] CODE_RSHIFT = 8'd229;

	// Matrix position to key number; rows past the map give key 0
	localparam logic [KEY_W-1:0] POS_TO_KEY [MAP_ROWS][COLUMNS] = '{
		'{23,  0, 20, 24, 15, 19, 16,  0},
		'{50, 52, 49, 51, 43, 46, 45, 41},
		'{36, 27, 48, 39, 30, 33, 44, 28},
		'{58, 60, 57, 59, 55, 47, 56, 42},
		'{22, 26, 21, 25, 14, 18, 17, 53},
		'{37, 40, 35, 38, 31, 34, 32, 29},
		'{ 8, 12,  7, 11,  0,  4,  3, 54},
		'{ 9, 13,  6, 10,  1,  5,  2,  0}
	};

	// Key number to HID usage code, one row per layer
	localparam logic [CODE_W-1:0] KEY_TO_CODE [LAYERS][KEYS] = '{
		'{41, 30, 31, 32, 33, 34, 35, 36, 37, 38, 39, 45, 46, 42,
		  43, 20, 26, 8, 21, 23, 28, 24, 12, 18, 19, 47, 48, 49,
		  57, 4, 22, 7, 9, 10, 11, 13, 14, 15, 51, 52, 40,
		  225, 29, 27, 6, 25, 5, 17, 16, 54, 55, 56, 229,
		  224, 0, 226, 44, 230, 231, 231, 228},
		'{53, 58, 59, 60, 61, 62, 63, 64, 65, 66, 67, 68, 69, 76,
		  43, 20, 26, 8, 21, 23, 28, 24, 73, 18, 19, 47, 48, 49,
		  57, 4, 22, 7, 9, 10, 80, 81, 82, 79, 51, 52, 40,
		  225, 29, 27, 6, 25, 5, 17, 16, 54, 55, 56, 229,
		  224, 0, 226, 44, 230, 231, 231, 228}
	};

	function automatic logic [KEY_W-1:0] pos_key(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		logic [KEY_W-1:0] k;
		k = '0;
		if (32'(row) < MAP_ROWS)
			k = POS_TO_KEY[row[$clog2(MAP_ROWS)-1:0]][col];
		return k;
	endfunction

	function automatic logic [CODE_W-1:0] key_code(input logic [LAYER_W-1:0] layer,
		input logic [KEY_W-1:0] key);
		logic [CODE_W-1:0] c;
		c = '0;
		if (32'(key) < KEYS)
			c = KEY_TO_CODE[layer][key];
		return c;
	endfunction

endpackage

[rtl/kms_scan_if.sv]
// Input channel: one column scan word (driven column and row levels).
interface kms_scan_if;
	import kms_pkg::*;

	logic             valid;
	logic             ready;
	logic [COL_W-1:0] column;
	logic [ROWS-1:0]  row_levels;

	modport source(output valid, output column, output row_levels, input ready);
	modport sink(input valid, input column, input row_levels, output ready);
endinterface

[rtl/kms_report_if.sv]
// Output channel: one key event or commit word.
interface kms_report_if;
	import kms_pkg::*;

	logic              valid;
	logic              ready;
	logic              has_event;
	logic [CODE_W-1:0] scancode;
	logic              pressed;
	logic              commit;
	logic              last;

	modport source(output valid, output has_event, output scancode, output pressed,
		output commit, output last, input ready);
	modport sink(input valid, input has_event, input scancode, input pressed,
		input commit, input last, output ready);
endinterface

[rtl/kms_keymap.sv]
// Key map unit: registered position-to-key lookup followed by key-to-scancode lookup.
module kms_keymap (
	input  logic                        clk,
	input  logic                        load,
	input  logic [kms_pkg::ROW_W-1:0]   row,
	input  logic [kms_pkg::COL_W-1:0]   col,
	input  logic [kms_pkg::LAYER_W-1:0] layer,
	output logic [kms_pkg::CODE_W-1:0]  code
);
	import kms_pkg::*;

	logic [KEY_W-1:0] key_q;

	// key number of the position under test
	always_ff @(posedge clk) begin
		if (load)
			key_q <= pos_key(row, col);
	end

	// layer is sampled live so a function key change mid-column takes effect
	assign code = key_code(layer, key_q);
endmodule

[rtl/key_matrix_scan_encoder_unit.sv]
// Top level of the key matrix scan encoder: row sequencer, key state and report register.
//
// Usage: the scan channel takes one word per driven column: the column index and
// the row levels, a low level meaning the key is held. Each row whose held state
// differs from the stored state produces a press or release word on the report
// channel, in row order. Escape released emits tilde release then escape
// release; escape pressed with a shift held emits tilde press. On column 7 the
// final word carries commit if any key changed over the scan; when column 7
// itself has no change but the scan had, a single commit-only word is sent.
// The final word of every scan word carries last; a scan word with no effect
// sends nothing.
// Timing: one sequencer walks the unchanged rows one per cycle, up to the topmost
// changed row, loading the key number as it goes; each changed row adds a code
// lookup state and a report word, and an escape release one more report word.
// The scan channel is ready only while idle. A stalled receiver holds the report
// word and the sequencer waits on it.
// Reset clears all key states, the shift state and the scan change flag.
module key_matrix_scan_encoder_unit (
	input  logic          clk,
	input  logic          arst_n,
	kms_scan_if.sink      scan,
	kms_report_if.source  report
);
	import kms_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_FIND, S_LOOK, S_WAIT} state_t;

	state_t            state_q;
	logic [ROWS-1:0]   key_held_q [COLUMNS];
	logic [1:0]        shift_q;
	logic              scan_changed_q;
	logic [COL_W-1:0]  col_q;
	logic [ROWS-1:0]   held_q;
	logic [ROWS-1:0]   mask_q;
	logic [ROW_W-1:0]  row_q;
	logic              commit_q;
	logic              esc_pend_q;
	logic              esc_last_q;
	logic              final_q;
	logic              out_valid_q;
	logic              out_has_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_pressed_q;
	logic              out_commit_q;
	logic              out_last_q;

	logic [CODE_W-1:0]  map_code;
	logic [LAYER_W-1:0] layer;
	logic [ROWS-1:0]    in_mask;
	logic [ROWS-1:0]    mask_rest;
	logic               row_top;
	logic               row_held;
	logic [CODE_W-1:0]  press_code;
	logic               out_take;

	// shift state follows every emitted event
	function automatic logic [1:0] next_shift(input logic [1:0] s,
		input logic [CODE_W-1:0] c, input logic p);
		logic [1:0] n;
		n = s;
		if (c == CODE_LSHIFT)
			n[0] = p;
		else if (c == CODE_RSHIFT)
			n[1] = p;
		return n;
	endfunction

	// layer comes from the stored function key state
	assign layer = LAYER_W'(key_held_q[FN_COL][FN_ROW]);

	kms_keymap u_keymap (
		.clk   (clk),
		.load  (state_q == S_FIND),
		.row   (row_q),
		.col   (col_q),
		.layer (layer),
		.code  (map_code)
	);

	// change mask of the incoming word and topmost-change test for the current row
	assign in_mask    = ~scan.row_levels ^ key_held_q[scan.column];
	assign mask_rest  = mask_q >> row_q;
	assign row_top    = (mask_rest[ROWS-1:1] == '0);
	assign row_held   = held_q[row_q];
	assign press_code = (map_code == CODE_ESC && shift_q != 2'b00) ? CODE_TILDE : map_code;
	assign out_take   = out_valid_q && report.ready;

	assign scan.ready       = (state_q == S_IDLE);
	assign report.valid     = out_valid_q;
	assign report.has_event = out_has_q;
	assign report.scancode  = out_code_q;
	assign report.pressed   = out_pressed_q;
	assign report.commit    = out_commit_q;
	assign report.last      = out_last_q;

	// sequencer, key state and report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			for (int c = 0; c < COLUMNS; c++)
				key_held_q[c] <= '0;
			shift_q        <= 2'b00;
			scan_changed_q <= 1'b0;
			esc_pend_q     <= 1'b0;
			final_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (scan.valid) begin
						col_q    <= scan.column;
						held_q   <= ~scan.row_levels;
						mask_q   <= in_mask;
						row_q    <= '0;
						commit_q <= (scan.column == LAST_COL) &&
							(scan_changed_q || in_mask != '0);
						if (scan.column == LAST_COL)
							scan_changed_q <= 1'b0;
						else if (in_mask != '0)
							scan_changed_q <= 1'b1;
						if (in_mask != '0) begin
							state_q <= S_FIND;
						end else if (scan.column == LAST_COL && scan_changed_q) begin
							// commit-only word
							out_valid_q   <= 1'b1;
							out_has_q     <= 1'b0;
							out_code_q    <= '0;
							out_pressed_q <= 1'b0;
							out_commit_q  <= 1'b1;
							out_last_q    <= 1'b1;
							final_q       <= 1'b1;
							esc_pend_q    <= 1'b0;
							state_q       <= S_WAIT;
						end
					end
				end
				S_FIND: begin
					// key map loads the key number of the current row; a changed row goes on to the lookup
					if (mask_q[row_q])
						state_q <= S_LOOK;
					else
						row_q <= row_q + ROW_W'(1);
				end
				S_LOOK: begin
					key_held_q[col_q][row_q] <= row_held;
					out_valid_q <= 1'b1;
					out_has_q   <= 1'b1;
					state_q     <= S_WAIT;
					if (row_held) begin
						out_code_q    <= press_code;
						out_pressed_q <= 1'b1;
						out_last_q    <= row_top;
						out_commit_q  <= row_top && commit_q;
						final_q       <= row_top;
						esc_pend_q    <= 1'b0;
						shift_q       <= next_shift(shift_q, press_code, 1'b1);
					end else if (map_code == CODE_ESC) begin
						// tilde release goes first, escape release follows
						out_code_q    <= CODE_TILDE;
						out_pressed_q <= 1'b0;
						out_last_q    <= 1'b0;
						out_commit_q  <= 1'b0;
						final_q       <= 1'b0;
						esc_pend_q    <= 1'b1;
						esc_last_q    <= row_top;
					end else begin
						out_code_q    <= map_code;
						out_pressed_q <= 1'b0;
						out_last_q    <= row_top;
						out_commit_q  <= row_top && commit_q;
						final_q       <= row_top;
						esc_pend_q    <= 1'b0;
						shift_q       <= next_shift(shift_q, map_code, 1'b0);
					end
				end
				S_WAIT: begin
					if (out_take) begin
						if (esc_pend_q) begin
							out_code_q    <= CODE_ESC;
							out_pressed_q <= 1'b0;
							out_last_q    <= esc_last_q;
							out_commit_q  <= esc_last_q && commit_q;
							final_q       <= esc_last_q;
							esc_pend_q    <= 1'b0;
						end else if (final_q) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							out_valid_q <= 1'b0;
							row_q       <= row_q + ROW_W'(1);
							state_q     <= S_FIND;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[tb/kms_event_monitor.sv]
// Passive monitor: predicts the report words of every accepted scan word and checks them.
`timescale 1ns / 1ps
module kms_event_monitor (
	input  logic  clk,
	input  logic  arst_n,
	kms_scan_if   scan,
	kms_report_if report,
	output int    errors,
	output int    outstanding,
	output int    checked,
	output int    commits,
	output int    tildes
);
	import kms_pkg::*;

	localparam int MAX_SCAN_WORDS = 2 * ROWS + 1;

	typedef struct packed {
		logic              has_event;
		logic [CODE_W-1:0] scancode;
		logic              pressed;
		logic              commit;
		logic              last;
	} report_word_t;

	// Predicted key matrix, shift state and scan change flag
	logic [COLUMNS-1:0] held_keys [ROWS];
	logic [1:0]         shift_state;
	logic               scan_dirty;

	report_word_t expected_words [$];
	report_word_t scan_words [MAX_SCAN_WORDS];
	int           scan_count;

	// Append one word of the current scan; shifts follow the emitted events
	task automatic add_word(input logic has, input logic [CODE_W-1:0] code, input logic down);
		scan_words[scan_count] = '{has, code, down, 1'b0, 1'b0};
		scan_count++;
		if (has && code == CODE_TILDE)
			tildes++;
		if (has && code == CODE_LSHIFT)
			shift_state[0] = down;
		else if (has && code == CODE_RSHIFT)
			shift_state[1] = down;
	endtask

	// Walk the rows of one column and queue the press/release words it causes
	task automatic predict_key_events(input logic [COL_W-1:0] col, input logic [ROWS-1:0] lv);
		logic               held;
		logic [LAYER_W-1:0] layer;
		logic [KEY_W-1:0]   key;
		logic [CODE_W-1:0]  code;
		scan_count = 0;
		if (int'(col) >= COLUMNS)
			return;
		for (int r = 0; r < ROWS; r++) begin
			held = !lv[r];
			// layer comes from the fn key as stored before this row is updated
			layer = LAYER_W'(held_keys[FN_ROW][FN_COL]);
			key = '0;
			if (r < MAP_ROWS)
				key = POS_TO_KEY[r][col];
			code = '0;
			if (int'(key) < KEYS)
				code = KEY_TO_CODE[layer][key];
			if (held != held_keys[r][col]) begin
				scan_dirty = 1'b1;
				held_keys[r][col] = held;
				if (held) begin
					// escape with a shift held turns into tilde
					if (code == CODE_ESC && shift_state != 2'b00)
						code = CODE_TILDE;
					add_word(1'b1, code, 1'b1);
				end else begin
					// escape release drops tilde first
					if (code == CODE_ESC)
						add_word(1'b1, CODE_TILDE, 1'b0);
					add_word(1'b1, code, 1'b0);
				end
			end
		end
		// end of scan: commit if anything changed, alone if this column was quiet
		if (col == LAST_COL) begin
			if (scan_dirty) begin
				if (scan_count == 0)
					add_word(1'b0, '0, 1'b0);
				scan_words[scan_count-1].commit = 1'b1;
			end
			scan_dirty = 1'b0;
		end
		if (scan_count != 0)
			scan_words[scan_count-1].last = 1'b1;
		for (int i = 0; i < scan_count; i++)
			expected_words.push_back(scan_words[i]);
	endtask

	// Sample both channels at the rising edge; predict first, then compare
	always @(posedge clk or negedge arst_n) begin
		report_word_t got;
		report_word_t want;
		if (!arst_n) begin
			foreach (held_keys[r])
				held_keys[r] = '0;
			shift_state = 2'b00;
			scan_dirty = 1'b0;
			expected_words.delete();
		end else begin
			if (scan.valid && scan.ready)
				predict_key_events(scan.column, scan.row_levels);
			if (report.valid && report.ready) begin
				got = '{report.has_event, report.scancode, report.pressed,
					report.commit, report.last};
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected report word: expected none, %s%0b %0d %0b %0b %0b",
						$time, "actual ev/code/press/commit/last ",
						got.has_event, got.scancode, got.pressed, got.commit, got.last);
				end else begin
					want = expected_words.pop_front();
					checked++;
					if (want.commit)
						commits++;
					if (got !== want) begin
						errors++;
						$display("%0t: report mismatch (ev/code/press/commit/last)", $time);
						$display("  expected %0b %0d %0b %0b %0b",
							want.has_event, want.scancode, want.pressed, want.commit,
							want.last);
						$display("  actual   %0b %0d %0b %0b %0b",
							got.has_event, got.scancode, got.pressed, got.commit,
							got.last);
					end
				end
			end
		end
		outstanding = expected_words.size();
	end

endmodule

[tb/key_matrix_scan_encoder_unit_tb.sv]
// Testbench top: clock, reset, scan word stimulus, report back-pressure and verdict.
`timescale 1ns / 1ps
module key_matrix_scan_encoder_unit_tb;
	import kms_pkg::*;

	localparam int RANDOM_ITEMS    = 403;
	localparam int WATCHDOG_CYCLES = 400_000;
	localparam int IDLE_PCT        = 28;
	// hot positions as row * 8 + column: shifts, escapes, fn key, an unmapped row
	localparam int HOT_KEYS [8] = '{15, 9, 1, 7, 63, 52, 55, 75};

	logic clk;
	logic arst_n;
	bit   calm;
	int   words_sent;
	int   pauses;
	int   errors;
	int   outstanding;
	int   checked;
	int   commits;
	int   tildes;

	logic [ROWS-1:0] levels_model [COLUMNS];

	kms_scan_if   scan_ch ();
	kms_report_if report_ch ();

	key_matrix_scan_encoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_ch),
		.report (report_ch)
	);

	kms_event_monitor event_mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.scan        (scan_ch),
		.report      (report_ch),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.commits     (commits),
		.tildes      (tildes)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		repeat (WATCHDOG_CYCLES) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	// Report back-pressure, off during the calm stretch
	initial begin
		report_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			report_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Send one scan word; entered and left on a falling edge
	task automatic drive_scan(input logic [COL_W-1:0] col, input logic [ROWS-1:0] lv);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			scan_ch.valid <= 1'b0;
			@(negedge clk);
		end
		scan_ch.valid      <= 1'b1;
		scan_ch.column     <= col;
		scan_ch.row_levels <= lv;
		@(posedge clk);
		while (!scan_ch.ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// Hold off the sender until every predicted word has come back
	task automatic wait_reports_drained();
		scan_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		pauses++;
	endtask

	initial begin
		int pos;
		int pick;
		int first;
		int stop;
		int next_pause;
		int directed_n;

		arst_n             = 1'b0;
		scan_ch.valid      = 1'b0;
		scan_ch.column     = '0;
		scan_ch.row_levels = '1;
		foreach (levels_model[c])
			levels_model[c] = '1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: full column, quiet and silent end of scan, shifts with escape
		drive_scan(COL_W'(0), 16'h0000);
		drive_scan(COL_W'(0), 16'hFFFF);
		drive_scan(COL_W'(7), 16'hFFFF);
		drive_scan(COL_W'(7), 16'hFFFF);
		drive_scan(COL_W'(7), 16'hFFFD);
		drive_scan(COL_W'(1), 16'hFFFE);
		drive_scan(COL_W'(1), 16'hFFFF);
		drive_scan(COL_W'(7), 16'hFFFF);
		drive_scan(COL_W'(1), 16'hFFFD);
		drive_scan(COL_W'(1), 16'hFFFC);
		drive_scan(COL_W'(1), 16'hFFFF);
		// fn layer, also switched in the middle of the last column
		drive_scan(COL_W'(7), 16'hFFBF);
		drive_scan(COL_W'(2), 16'h0000);
		drive_scan(COL_W'(2), 16'hFFFF);
		drive_scan(COL_W'(7), 16'h0000);
		drive_scan(COL_W'(7), 16'hFFFF);
		drive_scan(COL_W'(7), 16'h0000);
		drive_scan(COL_W'(7), 16'hFFFF);
		// alternating level patterns on the remaining columns
		drive_scan(COL_W'(3), 16'h5555);
		drive_scan(COL_W'(4), 16'hAAAA);
		drive_scan(COL_W'(5), 16'h0F0F);
		drive_scan(COL_W'(6), 16'hF0F0);
		for (int c = 3; c <= 6; c++)
			drive_scan(COL_W'(c), 16'hFFFF);
		drive_scan(COL_W'(7), 16'hFFFF);
		directed_n = words_sent;
		wait_reports_drained();
		next_pause = words_sent + 100;

		// Random: mostly full scans of a slowly changing matrix, some noise
		while (words_sent < directed_n + RANDOM_ITEMS) begin
			calm = (words_sent >= directed_n + 150) && (words_sent < directed_n + 270);
			if (words_sent >= next_pause) begin
				wait_reports_drained();
				next_pause = words_sent + 100;
			end
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if ($urandom_range(0, 19) == 0)
					foreach (levels_model[c])
						levels_model[c] = '1;
				repeat ($urandom_range(0, 3)) begin
					if ($urandom_range(0, 99) < 40)
						pos = HOT_KEYS[$urandom_range(0, 7)];
					else
						pos = $urandom_range(0, ROWS * COLUMNS - 1);
					levels_model[pos % COLUMNS][pos / COLUMNS] ^= 1'b1;
				end
				for (int c = 0; c < COLUMNS; c++)
					drive_scan(COL_W'(c), levels_model[c]);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 3))
					drive_scan(COL_W'($urandom_range(0, COLUMNS - 1)), ROWS'($urandom()));
			end else begin
				// broken scan: starts late, may stop early, one stray bit per column
				first = $urandom_range(0, COLUMNS - 1);
				stop  = $urandom_range(first, COLUMNS - 1);
				for (int c = first; c <= stop; c++)
					drive_scan(COL_W'(c),
						levels_model[c] ^ (ROWS'(1) << $urandom_range(0, ROWS - 1)));
			end
		end
		calm = 1'b0;

		wait_reports_drained();
		repeat (60) @(negedge clk);

		$display("Run covered %0d scan words (%0d directed), full and broken scans plus noise",
			words_sent, directed_n);
		$display("%0d report words checked, %0d commits, %0d tilde codes, %0d drain pauses",
			checked, commits, tildes, pauses);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
